/* src/hcps_pkg.sv */
// Constants, payload types and inter-stage structs for the halfcomplex
// power spectrum peak detector. No dependencies.
package hcps_pkg;

   localparam int MAX_FRAME   = 1024;
   localparam int MIN_FRAME   = 2;
   localparam int FRAME_W     = $clog2(MAX_FRAME) + 1;
   localparam int POS_W       = $clog2(MAX_FRAME);
   localparam int BIN_W       = $clog2(MAX_FRAME / 2) + 1;
   localparam int STORE_DEPTH = MAX_FRAME / 2;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int SAMPLE_W    = 16;
   localparam int POWER_W     = 2 * SAMPLE_W;
   localparam int TOTAL_W     = POWER_W + $clog2(MAX_FRAME / 2) ;

   // word after the request register
   typedef struct packed {
      logic                       track;
      logic                       use_re;
      logic                       last;
      logic [BIN_W-1:0]           bin;
      logic signed [SAMPLE_W-1:0] sample;
   } stage1_type;

   // bin power after the squaring stage
   typedef struct packed {
      logic               track;
      logic               last;
      logic [BIN_W-1:0]   bin;
      logic [POWER_W-1:0] power;
   } stage2_type;

endpackage

/* src/hcps_if.sv */
// Request, response and register-write channel interfaces.
// Depends on hcps_pkg.
interface hcps_req_if import hcps_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink (input valid, input sample, output ready);
endinterface

interface hcps_rsp_if import hcps_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [BIN_W-1:0]   bin_index;
   logic [POWER_W-1:0] bin_power;
   logic               frame_done;
   logic [BIN_W-1:0]   peak_bin;
   logic [POWER_W-1:0] peak_power;
   logic [BIN_W-1:0]   min_bin;
   logic [TOTAL_W-1:0] total_power;

   modport source (output valid, output bin_index, output bin_power, output frame_done,
                   output peak_bin, output peak_power, output min_bin, output total_power,
                   input ready);
   modport sink (input valid, input bin_index, input bin_power, input frame_done,
                 input peak_bin, input peak_power, input min_bin, input total_power,
                 output ready);
endinterface

interface hcps_csr_if import hcps_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [FRAME_W-1:0] frame_length;

   modport source (output valid, output frame_length, input ready);
   modport sink (input valid, input frame_length, output ready);
endinterface

/* src/halfcomplex_power_spectrum_peak.sv */
// Top level of the halfcomplex power spectrum peak detector.
// Depends on hcps_pkg, hcps_if, hcps_ram, hcps_front, hcps_power, hcps_track.
//
// Usage:
//  req_bus  : one halfcomplex word per request, r0, r1..r(N/2), then the
//             imaginary parts from the highest bin down to bin 1.
//  rsp_bus  : one response per DC word, Nyquist word (even N) and imaginary
//             word; real words of bins 1.. are stored and give no response.
//             The response of the last word of a frame has frame_done set and
//             carries peak bin, peak power, minimum bin and total power.
//  csr_bus  : frame length N, clamped to 2..1024; a write restarts the frame.
//             Write only while no request is in flight.
//  Throughput one request per clock unless stalled, set by the single read
//  and write port of the 512-entry real-part store and the two 16x16
//  squarers. A response passes the request, squaring and response registers.
//  Reset puts N at 1024, restarts the frame and empties the pipeline; the
//  store needs no clearing. When the receiver stalls, the response register
//  holds and the two internal stages keep filling before req_bus.ready drops.
module halfcomplex_power_spectrum_peak import hcps_pkg::*; (
   input logic        clock,
   input logic        reset,
   hcps_req_if.sink   req_bus,
   hcps_rsp_if.source rsp_bus,
   hcps_csr_if.sink   csr_bus
);

   logic                       s1_valid, s1_ready, s2_valid, s2_ready;
   stage1_type                 s1;
   stage2_type                 s2;
   logic                       wr_en, rd_en;
   logic [ADDR_W-1:0]          wr_addr, rd_addr;
   logic signed [SAMPLE_W-1:0] wr_data;
   logic [SAMPLE_W-1:0]        rd_data;

   hcps_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req      (req_bus),
      .csr      (csr_bus),
      .s1_ready (s1_ready),
      .s1_valid (s1_valid),
      .s1       (s1),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr)
   );

   hcps_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data ($unsigned(wr_data)),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   hcps_power u_power (
      .clock    (clock),
      .reset    (reset),
      .s1_valid (s1_valid),
      .s1       (s1),
      .re_data  ($signed(rd_data)),
      .s1_ready (s1_ready),
      .s2_ready (s2_ready),
      .s2_valid (s2_valid),
      .s2       (s2)
   );

   hcps_track u_track (
      .clock    (clock),
      .reset    (reset),
      .clear    (csr_bus.valid && csr_bus.ready),
      .s2_valid (s2_valid),
      .s2       (s2),
      .s2_ready (s2_ready),
      .rsp      (rsp_bus)
   );

endmodule

/* src/hcps_ram.sv */
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module hcps_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/hcps_front.sv */
// Frame position counter, length register, word decode and request register.
// Drives the real-part store ports. Depends on hcps_pkg and hcps_if.
module hcps_front import hcps_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   hcps_req_if.sink                   req,
   hcps_csr_if.sink                   csr,
   input  logic                       s1_ready,
   output logic                       s1_valid,
   output stage1_type                 s1,
   output logic                       wr_en,
   output logic [ADDR_W-1:0]          wr_addr,
   output logic signed [SAMPLE_W-1:0] wr_data,
   output logic                       rd_en,
   output logic [ADDR_W-1:0]          rd_addr
);

   logic [FRAME_W-1:0] length_ff, length_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic               s1_valid_ff, s1_valid_in;
   stage1_type         s1_ff, s1_in;

   logic               accept, csr_write;
   logic [FRAME_W-1:0] p_ext, half_ext, first_imag, bin_full, cfg_len;
   logic               is_dc, is_real, is_nyq, is_last;

   assign csr.ready = 1'b1;
   assign csr_write = csr.valid;
   assign req.ready = !s1_valid_ff || s1_ready;
   assign accept    = req.valid && req.ready;

   always_comb begin
      p_ext      = {1'b0, pos_ff};
      half_ext   = length_ff >> 1;
      first_imag = FRAME_W'((length_ff + FRAME_W'(1)) >> 1);
      bin_full   = length_ff - p_ext;
      is_dc      = (pos_ff == '0);
      is_real    = !is_dc && (p_ext < first_imag);
      is_nyq     = !is_dc && !is_real && !length_ff[0] && (p_ext == half_ext);
      is_last    = (p_ext == length_ff - FRAME_W'(1));

      s1_in.sample = req.sample;
      s1_in.last   = is_last;
      s1_in.track  = !is_dc;
      s1_in.use_re = !is_dc && !is_nyq;
      if (is_dc) begin
         s1_in.bin = '0;
      end else if (is_nyq) begin
         s1_in.bin = half_ext[BIN_W-1:0];
      end else begin
         s1_in.bin = bin_full[BIN_W-1:0];
      end
   end

   assign wr_en   = accept && is_real;
   assign wr_addr = pos_ff[ADDR_W-1:0];
   assign wr_data = req.sample;
   assign rd_en   = accept && !is_dc && !is_real && !is_nyq;
   assign rd_addr = bin_full[ADDR_W-1:0];

   always_comb begin
      if (csr.frame_length < FRAME_W'(MIN_FRAME)) begin
         cfg_len = FRAME_W'(MIN_FRAME);
      end else if (csr.frame_length > FRAME_W'(MAX_FRAME)) begin
         cfg_len = FRAME_W'(MAX_FRAME);
      end else begin
         cfg_len = csr.frame_length;
      end

      length_in = length_ff;
      pos_in    = pos_ff;
      if (csr_write) begin
         length_in = cfg_len;
         pos_in    = '0;
      end else if (accept) begin
         pos_in = is_last ? '0 : POS_W'(pos_ff + POS_W'(1));
      end

      s1_valid_in = s1_valid_ff;
      if (req.ready) begin
         s1_valid_in = accept && !is_real;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff   <= FRAME_W'(MAX_FRAME);
         pos_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         length_ff   <= length_in;
         pos_ff      <= pos_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= s1_in;
      end
   end

   assign s1_valid = s1_valid_ff;
   assign s1       = s1_ff;

`ifndef SYNTHESIS
   a_pos_in_frame: assert property (@(posedge clock) disable iff (reset)
      {1'b0, pos_ff} < length_ff)
      else $error("frame position beyond frame length");
   a_length_range: assert property (@(posedge clock) disable iff (reset)
      length_ff >= FRAME_W'(MIN_FRAME) && length_ff <= FRAME_W'(MAX_FRAME))
      else $error("frame length out of range");
   a_store_one_port: assert property (@(posedge clock) disable iff (reset)
      !(wr_en && rd_en))
      else $error("store written and read by one request");
`endif

endmodule

/* src/hcps_power.sv */
// Squaring stage: re^2 + im^2 of a bin, or im^2 alone for DC and Nyquist, registered.
// Depends on hcps_pkg.
module hcps_power import hcps_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       s1_valid,
   input  stage1_type                 s1,
   input  logic signed [SAMPLE_W-1:0] re_data,
   output logic                       s1_ready,
   input  logic                       s2_ready,
   output logic                       s2_valid,
   output stage2_type                 s2
);

   logic              s2_valid_ff, s2_valid_in;
   stage2_type        s2_ff, s2_in;
   logic signed [POWER_W-1:0] sq_im, sq_re;

   assign s1_ready = !s2_valid_ff || s2_ready;

   always_comb begin
      sq_im = POWER_W'(s1.sample) * POWER_W'(s1.sample);
      sq_re = POWER_W'(re_data) * POWER_W'(re_data);
      s2_in.track = s1.track;
      s2_in.last  = s1.last;
      s2_in.bin   = s1.bin;
      s2_in.power = s1.use_re ? POWER_W'($unsigned(sq_im) + $unsigned(sq_re))
                              : $unsigned(sq_im);
      s2_valid_in = s1_ready ? s1_valid : s2_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && s1_valid) begin
         s2_ff <= s2_in;
      end
   end

   assign s2_valid = s2_valid_ff;
   assign s2       = s2_ff;

endmodule

/* src/hcps_track.sv */
// Peak, minimum and total tracking over bins 1..N/2, and the response register.
// Depends on hcps_pkg and hcps_if.
module hcps_track import hcps_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       clear,
   input  logic       s2_valid,
   input  stage2_type s2,
   output logic       s2_ready,
   hcps_rsp_if.source rsp
);

   logic               seen_ff, seen_in;
   logic [POWER_W-1:0] best_ff, best_in, least_ff, least_in;
   logic [BIN_W-1:0]   best_bin_ff, best_bin_in, least_bin_ff, least_bin_in;
   logic [TOTAL_W-1:0] sum_ff, sum_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic [BIN_W-1:0]   bin_ff, peak_bin_ff, min_bin_ff;
   logic [POWER_W-1:0] power_ff, peak_power_ff;
   logic               done_ff;
   logic [TOTAL_W-1:0] total_ff;

   logic               adv;
   logic               take_best, take_least;
   logic [POWER_W-1:0] best_n, least_n;
   logic [BIN_W-1:0]   best_bin_n, least_bin_n;
   logic [TOTAL_W-1:0] sum_n;

   assign s2_ready = !rsp_valid_ff || rsp.ready;
   assign adv      = s2_valid && s2_ready;

   always_comb begin
      take_best  = !seen_ff || (s2.power >= best_ff);
      take_least = !seen_ff || (s2.power <= least_ff);
      best_n      = best_ff;
      best_bin_n  = best_bin_ff;
      least_n     = least_ff;
      least_bin_n = least_bin_ff;
      sum_n       = sum_ff;
      if (s2.track) begin
         if (take_best) begin
            best_n     = s2.power;
            best_bin_n = s2.bin;
         end
         if (take_least) begin
            least_n     = s2.power;
            least_bin_n = s2.bin;
         end
         sum_n = TOTAL_W'(sum_ff + TOTAL_W'(s2.power));
      end

      seen_in      = seen_ff;
      best_in      = best_ff;
      best_bin_in  = best_bin_ff;
      least_in     = least_ff;
      least_bin_in = least_bin_ff;
      sum_in       = sum_ff;
      if (clear || (adv && s2.last)) begin
         seen_in      = 1'b0;
         best_in      = '0;
         best_bin_in  = '0;
         least_in     = '0;
         least_bin_in = '0;
         sum_in       = '0;
      end else if (adv) begin
         seen_in      = seen_ff || s2.track;
         best_in      = best_n;
         best_bin_in  = best_bin_n;
         least_in     = least_n;
         least_bin_in = least_bin_n;
         sum_in       = sum_n;
      end

      rsp_valid_in = s2_ready ? s2_valid : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff      <= 1'b0;
         best_ff      <= '0;
         best_bin_ff  <= '0;
         least_ff     <= '0;
         least_bin_ff <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         seen_ff      <= seen_in;
         best_ff      <= best_in;
         best_bin_ff  <= best_bin_in;
         least_ff     <= least_in;
         least_bin_ff <= least_bin_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         bin_ff        <= s2.bin;
         power_ff      <= s2.power;
         done_ff       <= s2.last;
         peak_bin_ff   <= s2.last ? best_bin_n : '0;
         peak_power_ff <= s2.last ? best_n : '0;
         min_bin_ff    <= s2.last ? least_bin_n : '0;
         total_ff      <= s2.last ? sum_n : '0;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.bin_index   = bin_ff;
   assign rsp.bin_power   = power_ff;
   assign rsp.frame_done  = done_ff;
   assign rsp.peak_bin    = peak_bin_ff;
   assign rsp.peak_power  = peak_power_ff;
   assign rsp.min_bin     = min_bin_ff;
   assign rsp.total_power = total_ff;

`ifndef SYNTHESIS
   a_order: assert property (@(posedge clock) disable iff (reset)
      seen_ff |-> least_ff <= best_ff)
      else $error("minimum power above peak power");
   a_idle_clear: assert property (@(posedge clock) disable iff (reset)
      !seen_ff |-> sum_ff == '0 && best_ff == '0 && least_ff == '0)
      else $error("statistics not clear at frame start");
   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      seen_ff |-> sum_ff >= TOTAL_W'(best_ff))
      else $error("total power below peak power");
`endif

endmodule
